// ===== rtl/hbr_pkg.sv =====
// ----------------------------------------------------------------------------
// hbr_pkg: shared types and constants for the H-bridge PWM speed ramp unit
// Command codes, widths and the request/response structs of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package hbr_pkg;

    localparam int PERIOD_W = 16;
    localparam int SPEED_W  = 7;
    localparam int IV_W     = 10;
    localparam int DIVD_W   = 23;   // 16-bit period times 7-bit speed
    localparam int DIVS_W   = 7;
    localparam int DCNT_W   = 5;

    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_START_RMP = 3'd2;
    localparam logic [2:0] MODE_SET_SPEED = 3'd3;
    localparam logic [2:0] MODE_STOP     = 3'd4;
    localparam logic [2:0] MODE_BRAKE    = 3'd5;

    localparam logic [SPEED_W-1:0]  SPEED_MAX          = 7'd100;
    localparam logic [IV_W-1:0]     MAX_INTERVAL_TICKS = 10'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET       = 16'd999;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/hbr_in_if.sv =====
// ----------------------------------------------------------------------------
// hbr_in_if: command channel of the speed ramp unit
// Valid/ready handshake carrying one command request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic        direction;
    logic [7:0]  speed;
    logic [15:0] ramp_time;

    modport source (output valid, mode, direction, speed, ramp_time, input ready);
    modport sink   (input valid, mode, direction, speed, ramp_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/hbr_out_if.sv =====
// ----------------------------------------------------------------------------
// hbr_out_if: result channel of the speed ramp unit
// Valid/ready handshake carrying the compare values and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [6:0]  speed_now;
    logic        ramp_active;
    logic        motor_running;

    modport source (output valid, compare_a, compare_b, speed_now, ramp_active,
                    motor_running, input ready);
    modport sink   (input valid, compare_a, compare_b, speed_now, ramp_active,
                    motor_running, output ready);
endinterface

`default_nettype wire

// ===== rtl/hbr_div.sv =====
// ----------------------------------------------------------------------------
// hbr_div: shared restoring divider
// One quotient bit per cycle; serves both the duty scaling and the ramp
// interval calculation.
// ----------------------------------------------------------------------------
`default_nettype none

module hbr_div
    import hbr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   w_part;
    logic              w_ge;
    logic [DIVS_W:0]   w_diff;

    assign w_part = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge   = (w_part >= {1'b0, r_dvs});
    assign w_diff = w_part - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so seven bits suffice
            r_rem <= w_ge ? w_diff[DIVS_W-1:0] : w_part[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
        end
    end

    assign o_rsp = '{done: r_done, quotient: r_quo};

endmodule

`default_nettype wire

// ===== rtl/h_bridge_pwm_speed_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// h_bridge_pwm_speed_ramp_unit: H-bridge PWM compare generator with speed ramp
// Commands set, ramp, stop or brake the motor; 1 ms ticks advance a ramp.
// ----------------------------------------------------------------------------
// Each command request yields one result. A request that changes the duty
// (start, set speed, a ramp step) passes from acceptance to result through
// a decode state, a multiply state for the duty, the shared bit-serial divider
// for period*speed/100 (23 quotient bits, then a completion flag) and a state
// that loads the result. A ramped start feeds duration/steps to the divider
// straight from decode. Other requests go from decode to the load state. The
// unit is ready again the cycle after a result is loaded; that result may
// still be waiting in the output register, and a finished request holds until
// the output register is free. Write pwm_period through i_cfg_we/i_cfg_wdata
// only while the unit is idle; the unit itself does not enforce this.
`default_nettype none

module h_bridge_pwm_speed_ramp_unit
    import hbr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_wdata,
    hbr_in_if.sink                   i_cmd,
    hbr_out_if.source                o_res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [PERIOD_W-1:0] r_period;

    // latched request
    logic [2:0]          r_mode;
    logic                r_dir_in;
    logic [SPEED_W-1:0]  r_spd;
    logic [15:0]         r_dur;

    // controller state
    logic [SPEED_W-1:0]  r_speed_cur, n_speed_cur;
    logic [SPEED_W-1:0]  r_speed_goal, n_speed_goal;
    logic                r_step_down, n_step_down;
    logic                r_dir, n_dir;
    logic                r_running, n_running;
    logic                r_ramping, n_ramping;
    logic [IV_W-1:0]     r_step_iv, n_step_iv;
    logic [IV_W-1:0]     r_tick_cnt, n_tick_cnt;
    logic [PERIOD_W-1:0] r_cmp_a, n_cmp_a;
    logic [PERIOD_W-1:0] r_cmp_b, n_cmp_b;
    logic [SPEED_W-1:0]  r_apply_spd, n_apply_spd;
    logic                r_job_iv, n_job_iv;

    // result register
    logic                r_out_valid;
    logic [PERIOD_W-1:0] r_out_a;
    logic [PERIOD_W-1:0] r_out_b;
    logic [SPEED_W-1:0]  r_out_spd;
    logic                r_out_ramp;
    logic                r_out_run;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    logic                w_accept;
    logic                w_out_take;
    logic [IV_W-1:0]     w_tick_inc;
    logic [SPEED_W-1:0]  w_steps;
    logic [SPEED_W-1:0]  w_step_spd;
    logic [SPEED_W-1:0]  w_up_spd;
    logic [DIVD_W-1:0]   w_quo;
    logic [PERIOD_W-1:0] w_pulse;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_take = r_out_valid && o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && i_rst_n;

    assign w_tick_inc = r_tick_cnt + 1'b1;
    assign w_steps    = (r_spd > r_speed_cur) ? (r_spd - r_speed_cur)
                                              : (r_speed_cur - r_spd);
    assign w_up_spd   = (r_speed_cur >= SPEED_MAX) ? SPEED_MAX : (r_speed_cur + 1'b1);
    assign w_quo      = w_div_rsp.quotient;
    assign w_pulse    = w_quo[PERIOD_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_speed_cur  = r_speed_cur;
        n_speed_goal = r_speed_goal;
        n_step_down  = r_step_down;
        n_dir        = r_dir;
        n_running    = r_running;
        n_ramping    = r_ramping;
        n_step_iv    = r_step_iv;
        n_tick_cnt   = r_tick_cnt;
        n_cmp_a      = r_cmp_a;
        n_cmp_b      = r_cmp_b;
        n_apply_spd  = r_apply_spd;
        n_job_iv     = r_job_iv;
        w_step_spd   = r_speed_cur;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = DIVD_W'(r_period) * DIVD_W'(r_apply_spd);
        w_div_req.divisor  = SPEED_MAX;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state  = S_DONE;
                n_job_iv = 1'b0;
                unique case (r_mode)
                    MODE_TICK: begin
                        if (r_ramping) begin
                            if (w_tick_inc >= r_step_iv) begin
                                n_tick_cnt = '0;
                                if (r_step_down) begin
                                    if (r_speed_cur != '0) begin
                                        w_step_spd = r_speed_cur - 1'b1;
                                        n_state    = S_MUL;
                                    end
                                end else begin
                                    w_step_spd = w_up_spd;
                                    n_state    = S_MUL;
                                end
                                n_speed_cur = w_step_spd;
                                n_apply_spd = w_step_spd;
                                if (w_step_spd == r_speed_goal) begin
                                    n_ramping = 1'b0;
                                    if (r_speed_goal == '0) begin
                                        n_running = 1'b0;
                                    end
                                end
                            end else begin
                                n_tick_cnt = w_tick_inc;
                            end
                        end
                    end
                    MODE_START: begin
                        n_ramping   = 1'b0;
                        n_dir       = r_dir_in;
                        n_running   = 1'b1;
                        n_speed_cur = r_spd;
                        n_apply_spd = r_spd;
                        n_state     = S_MUL;
                    end
                    MODE_START_RMP: begin
                        if (!r_ramping && (r_spd != r_speed_cur)) begin
                            n_dir        = r_dir_in;
                            n_running    = 1'b1;
                            n_speed_goal = r_spd;
                            n_step_down  = (r_spd < r_speed_cur);
                            n_ramping    = 1'b1;
                            n_tick_cnt   = '0;
                            n_job_iv     = 1'b1;
                            w_div_req.start    = 1'b1;
                            w_div_req.dividend = DIVD_W'(r_dur);
                            w_div_req.divisor  = w_steps;
                            n_state      = S_DIV;
                        end
                    end
                    MODE_SET_SPEED: begin
                        if (r_running) begin
                            n_ramping   = 1'b0;
                            n_speed_cur = r_spd;
                            n_apply_spd = r_spd;
                            n_state     = S_MUL;
                        end
                    end
                    MODE_STOP: begin
                        n_ramping   = 1'b0;
                        n_running   = 1'b0;
                        n_speed_cur = '0;
                        n_cmp_a     = '0;
                        n_cmp_b     = '0;
                    end
                    MODE_BRAKE: begin
                        n_ramping   = 1'b0;
                        n_running   = 1'b0;
                        n_speed_cur = '0;
                        n_cmp_a     = r_period;
                        n_cmp_b     = r_period;
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                // product goes straight into the divider's dividend register
                w_div_req.start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                    if (r_job_iv) begin
                        if (w_quo == '0) begin
                            n_step_iv = IV_W'(1);
                        end else if (w_quo > DIVD_W'(MAX_INTERVAL_TICKS)) begin
                            n_step_iv = MAX_INTERVAL_TICKS;
                        end else begin
                            n_step_iv = w_quo[IV_W-1:0];
                        end
                    end else if (r_dir) begin
                        n_cmp_a = '0;
                        n_cmp_b = w_pulse;
                    end else begin
                        n_cmp_a = w_pulse;
                        n_cmp_b = '0;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_period     <= PERIOD_RESET;
            r_speed_cur  <= '0;
            r_speed_goal <= '0;
            r_step_down  <= 1'b0;
            r_dir        <= 1'b0;
            r_running    <= 1'b0;
            r_ramping    <= 1'b0;
            r_step_iv    <= IV_W'(1);
            r_tick_cnt   <= '0;
            r_cmp_a      <= '0;
            r_cmp_b      <= '0;
            r_job_iv     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_speed_cur  <= n_speed_cur;
            r_speed_goal <= n_speed_goal;
            r_step_down  <= n_step_down;
            r_dir        <= n_dir;
            r_running    <= n_running;
            r_ramping    <= n_ramping;
            r_step_iv    <= n_step_iv;
            r_tick_cnt   <= n_tick_cnt;
            r_cmp_a      <= n_cmp_a;
            r_cmp_b      <= n_cmp_b;
            r_job_iv     <= n_job_iv;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_apply_spd <= n_apply_spd;
        if (w_accept) begin
            r_mode   <= i_cmd.mode;
            r_dir_in <= i_cmd.direction;
            r_spd    <= (i_cmd.speed > 8'(SPEED_MAX)) ? SPEED_MAX
                                                      : i_cmd.speed[SPEED_W-1:0];
            r_dur    <= i_cmd.ramp_time;
        end
        if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
            r_out_a    <= r_cmp_a;
            r_out_b    <= r_cmp_b;
            r_out_spd  <= r_speed_cur;
            r_out_ramp <= r_ramping;
            r_out_run  <= r_running;
        end
    end

    hbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_res.valid         = r_out_valid;
    assign o_res.compare_a     = r_out_a;
    assign o_res.compare_b     = r_out_b;
    assign o_res.speed_now     = r_out_spd;
    assign o_res.ramp_active   = r_out_ramp;
    assign o_res.motor_running = r_out_run;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside the divide phase");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed_cur <= SPEED_MAX)
        else $error("current speed above full scale");

    a_ramp_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ramping |-> r_running)
        else $error("ramp active while the motor is not driven");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DECIDE))
        else $error("accepted request not decoded");

endmodule

`default_nettype wire

// ===== dv/tb_h_bridge_pwm_speed_ramp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_h_bridge_pwm_speed_ramp_unit: self-checking bench for the speed ramp unit
// A short table of commands runs first. Random command sequences follow under
// several PWM periods. Each result is checked against the row's expected drive
// for typed table rows, else against an in-bench model of the bridge drive.
// The sender works in bursts, and the receiver stalls.

module tb_h_bridge_pwm_speed_ramp_unit
    import hbr_pkg::*;
();

    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
    localparam int         RAND_PER_PHASE = 200;
    localparam int         NUM_PHASES     = 5;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
        logic [6:0]  speed;
        logic        ramping;
        logic        running;
    } t_drive;

    typedef struct packed {
        logic [2:0]  mode;
        logic        dir;
        logic [7:0]  speed;
        logic [15:0] dur;
        logic        typed;
        t_drive      want;
    } t_cmd_row;

    localparam t_drive IDLE_DRIVE = '0;

    localparam t_cmd_row CMD_TABLE [26] = '{
        '{MODE_TICK,      1'b0, 8'd0,   16'd0,     1'b1, IDLE_DRIVE},
        '{MODE_UNUSED_6,  1'b1, 8'd255, 16'hFFFF,  1'b1, IDLE_DRIVE},
        '{MODE_UNUSED_7,  1'b0, 8'd0,   16'd0,     1'b1, IDLE_DRIVE},
        '{MODE_SET_SPEED, 1'b0, 8'd50,  16'd0,     1'b1, IDLE_DRIVE},
        '{MODE_START,     1'b0, 8'd255, 16'hFFFF,  1'b1,
          '{16'd999, 16'd0, 7'd100, 1'b0, 1'b1}},
        '{MODE_START,     1'b1, 8'd100, 16'd0,     1'b1,
          '{16'd0, 16'd999, 7'd100, 1'b0, 1'b1}},
        '{MODE_SET_SPEED, 1'b0, 8'd0,   16'd0,     1'b1,
          '{16'd0, 16'd0, 7'd0, 1'b0, 1'b1}},
        '{MODE_BRAKE,     1'b0, 8'd0,   16'd0,     1'b1,
          '{16'd999, 16'd999, 7'd0, 1'b0, 1'b0}},
        '{MODE_STOP,      1'b0, 8'd0,   16'd0,     1'b1, IDLE_DRIVE},
        '{MODE_START_RMP, 1'b0, 8'd3,   16'd0,     1'b1,
          '{16'd0, 16'd0, 7'd0, 1'b1, 1'b1}},
        '{MODE_START_RMP, 1'b1, 8'd90,  16'hFFFF,  1'b0, IDLE_DRIVE},
        '{MODE_TICK,      1'b0, 8'd0,   16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_TICK,      1'b1, 8'd200, 16'd7,     1'b0, IDLE_DRIVE},
        '{MODE_TICK,      1'b0, 8'd0,   16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_START_RMP, 1'b1, 8'd3,   16'd100,   1'b0, IDLE_DRIVE},
        '{MODE_START_RMP, 1'b1, 8'd4,   16'hFFFF,  1'b0, IDLE_DRIVE},
        '{MODE_TICK,      1'b0, 8'd0,   16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_SET_SPEED, 1'b1, 8'd2,   16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_START_RMP, 1'b1, 8'd0,   16'd1,     1'b0, IDLE_DRIVE},
        '{MODE_TICK,      1'b0, 8'd0,   16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_TICK,      1'b0, 8'd0,   16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_START_RMP, 1'b0, 8'd100, 16'd200,   1'b0, IDLE_DRIVE},
        '{MODE_TICK,      1'b0, 8'd0,   16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_BRAKE,     1'b1, 8'd77,  16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_START_RMP, 1'b0, 8'd50,  16'd0,     1'b0, IDLE_DRIVE},
        '{MODE_START,     1'b1, 8'd255, 16'd0,     1'b0, IDLE_DRIVE}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PERIOD_W-1:0] i_cfg_wdata;

    hbr_in_if  cmd_if ();
    hbr_out_if res_if ();

    h_bridge_pwm_speed_ramp_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    // Model of the bridge drive
    logic [15:0] period_q;
    logic [6:0]  speed_q;
    logic [6:0]  goal_q;
    logic        ramp_down_q;
    logic        dir_q;
    logic        running_q;
    logic        ramping_q;
    logic [9:0]  interval_q;
    logic [9:0]  ticks_q;
    logic [15:0] cmp_a_q;
    logic [15:0] cmp_b_q;

    t_drive pending_drive [$];
    int     err_count;
    int     burst_left;
    bit     hold_req;

    function automatic void set_duty(input logic [6:0] spd);
        logic [31:0] pulse;
        if (spd > SPEED_MAX) spd = SPEED_MAX;
        speed_q = spd;
        pulse   = (32'(period_q) * 32'(spd)) / 32'(SPEED_MAX);
        cmp_a_q = dir_q ? 16'd0 : pulse[15:0];
        cmp_b_q = dir_q ? pulse[15:0] : 16'd0;
    endfunction

    function automatic t_drive drive_update(input logic [2:0] mode, input logic dir,
                                            input logic [7:0] spd_in,
                                            input logic [15:0] dur);
        logic [6:0]  spd;
        logic [6:0]  steps;
        logic [15:0] iv;
        spd = (spd_in > 8'(SPEED_MAX)) ? SPEED_MAX : spd_in[6:0];
        case (mode)
            MODE_TICK: begin
                if (ramping_q) begin
                    ticks_q = ticks_q + 10'd1;
                    if (ticks_q >= interval_q) begin
                        ticks_q = '0;
                        if (ramp_down_q) begin
                            if (speed_q > 0) set_duty(speed_q - 7'd1);
                        end else begin
                            set_duty(speed_q + 7'd1);
                        end
                        if (speed_q == goal_q) begin
                            ramping_q = 1'b0;
                            if (goal_q == 0) running_q = 1'b0;
                        end
                    end
                end
            end
            MODE_START: begin
                ramping_q = 1'b0;
                dir_q     = dir;
                running_q = 1'b1;
                set_duty(spd);
            end
            MODE_START_RMP: begin
                if (!ramping_q && spd != speed_q) begin
                    steps = (spd > speed_q) ? spd - speed_q : speed_q - spd;
                    iv    = dur / 16'(steps);
                    if (iv == 0) iv = 16'd1;
                    if (iv > 16'(MAX_INTERVAL_TICKS)) iv = 16'(MAX_INTERVAL_TICKS);
                    dir_q       = dir;
                    running_q   = 1'b1;
                    goal_q      = spd;
                    ramp_down_q = spd < speed_q;
                    ramping_q   = 1'b1;
                    interval_q  = iv[9:0];
                    ticks_q     = '0;
                end
            end
            MODE_SET_SPEED: begin
                if (running_q) begin
                    ramping_q = 1'b0;
                    set_duty(spd);
                end
            end
            MODE_STOP: begin
                ramping_q = 1'b0;
                cmp_a_q   = '0;
                cmp_b_q   = '0;
                running_q = 1'b0;
                speed_q   = '0;
            end
            MODE_BRAKE: begin
                ramping_q = 1'b0;
                cmp_a_q   = period_q;
                cmp_b_q   = period_q;
                running_q = 1'b0;
                speed_q   = '0;
            end
            default: ;
        endcase
        return '{cmp_a_q, cmp_b_q, speed_q, ramping_q, running_q};
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Offer one request; model it at the edge it is taken.
    // Entered and left in the time step of a rising edge.
    task automatic send_cmd(input logic [2:0] mode, input logic dir, input logic [7:0] spd,
                            input logic [15:0] dur, input logic typed, input t_drive want);
        int     gap;
        t_drive model;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.mode      <= mode;
        cmd_if.direction <= dir;
        cmd_if.speed     <= spd;
        cmd_if.ramp_time <= dur;
        do @(posedge i_clk); while (!cmd_if.ready);
        model = drive_update(mode, dir, spd, dur);
        pending_drive.push_back(typed ? want : model);
        burst_left--;
    endtask

    // Drop the request line and let the unit drain before touching the period
    task automatic write_period(input logic [15:0] value);
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        period_q = value;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: stall patterns of its own, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        int pat_kind;
        int pat_left;
        int pat_cnt;
        hold_left = 0;
        pat_kind  = 0;
        pat_left  = 0;
        pat_cnt   = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_kind = $urandom_range(0, 2);
                    pat_left = $urandom_range(20, 120);
                end
                pat_left--;
                pat_cnt++;
                case (pat_kind)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= ($urandom_range(0, 2) != 0);
                    default: res_if.ready <= ((pat_cnt % 5) >= 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_drive want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_drive.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_drive.pop_front();
                if (res_if.compare_a !== want.cmp_a)
                    report_mismatch($sformatf("compare_a got %0d exp %0d",
                                              res_if.compare_a, want.cmp_a));
                if (res_if.compare_b !== want.cmp_b)
                    report_mismatch($sformatf("compare_b got %0d exp %0d",
                                              res_if.compare_b, want.cmp_b));
                if (res_if.speed_now !== want.speed)
                    report_mismatch($sformatf("speed_now got %0d exp %0d",
                                              res_if.speed_now, want.speed));
                if (res_if.ramp_active !== want.ramping)
                    report_mismatch($sformatf("ramp_active got %0b exp %0b",
                                              res_if.ramp_active, want.ramping));
                if (res_if.motor_running !== want.running)
                    report_mismatch($sformatf("motor_running got %0b exp %0b",
                                              res_if.motor_running, want.running));
            end
        end
    end

    initial begin : stimulus
        logic [15:0] periods [NUM_PHASES];
        logic [2:0]  mode;
        logic [7:0]  spd;
        logic [6:0]  spd_c;
        logic [6:0]  steps;
        logic [15:0] dur;
        int          r;
        int          counted;
        err_count  = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        period_q    = PERIOD_RESET;
        speed_q     = '0;
        goal_q      = '0;
        ramp_down_q = 1'b0;
        dir_q       = 1'b0;
        running_q   = 1'b0;
        ramping_q   = 1'b0;
        interval_q  = 10'd1;
        ticks_q     = '0;
        cmp_a_q     = '0;
        cmp_b_q     = '0;
        periods = '{PERIOD_RESET, 16'hFFFF, 16'd0, 16'($urandom_range(0, 65535)), 16'd1};

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        cmd_if.valid     <= 1'b0;
        cmd_if.mode      <= MODE_TICK;
        cmd_if.direction <= 1'b0;
        cmd_if.speed     <= '0;
        cmd_if.ramp_time <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CMD_TABLE[i])
            send_cmd(CMD_TABLE[i].mode, CMD_TABLE[i].dir, CMD_TABLE[i].speed,
                     CMD_TABLE[i].dur, CMD_TABLE[i].typed, CMD_TABLE[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) write_period(periods[ph]);
            // Hold the result side off so the unit backs up into the command side
            if (ph == 1) hold_req = 1'b1;
            counted = 0;
            while (counted < RAND_PER_PHASE) begin
                r = $urandom_range(0, 99);
                // While a ramp runs, mostly advance it; otherwise mostly command
                if (ramping_q && r < 80)  mode = MODE_TICK;
                else if (r < 3)           mode = MODE_TICK;
                else if (r < 5)           mode = ($urandom_range(0, 1) != 0) ? MODE_UNUSED_6
                                                                             : MODE_UNUSED_7;
                else if (r < 45)          mode = MODE_START_RMP;
                else if (r < 60)          mode = MODE_START;
                else if (r < 75)          mode = MODE_SET_SPEED;
                else if (r < 88)          mode = MODE_STOP;
                else                      mode = MODE_BRAKE;
                spd = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 100));
                spd_c = (spd > 8'(SPEED_MAX)) ? SPEED_MAX : spd[6:0];
                steps = (spd_c > speed_q) ? spd_c - speed_q : speed_q - spd_c;
                r = $urandom_range(0, 99);
                if (r < 75)       dur = 16'(32'(steps) * $urandom_range(0, 4));
                else if (r < 95)  dur = 16'($urandom_range(0, 65535));
                else              dur = 16'hFFFF;
                if (!(mode == MODE_TICK && !ramping_q) && mode != MODE_UNUSED_6
                        && mode != MODE_UNUSED_7)
                    counted++;
                send_cmd(mode, 1'($urandom_range(0, 1)), spd, dur, 1'b0, IDLE_DRIVE);
            end
        end

        cmd_if.valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_drive.size() != 0) report_mismatch("requests left without result");
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
